>>> rtl/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam logic [7:0]  SYNC_A        = 8'h21;
  localparam logic [7:0]  SYNC_B        = 8'h50;
  localparam logic [7:0]  SYNC_C        = 8'h53;
  localparam logic [15:0] MAX_LEN_RESET = 16'd119;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_REPORT  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR  = 2'd2;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_HUNT3   = 4'd2,
    PH_ID      = 4'd3,
    PH_CMD_LO  = 4'd4,
    PH_CMD_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_LEN_HI  = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_CHECK   = 4'd9
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_stage_t;

  typedef struct packed {
    logic        valid;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_id;
    logic [15:0] command_word;
    logic [15:0] payload_len;
    logic [1:0]  frame_status;
  } result_t;

endpackage

>>> rtl/frp_in_reg.sv
// ----------------------------------------------------------------------------
// frp_in_reg
// Input register holding one received byte until the deframer takes it.
// ----------------------------------------------------------------------------
module frp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  input  logic              take_i,
  output frp_pkg::in_stage_t stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_axis_tdata;
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.rx_byte = byte_q;

endmodule

>>> rtl/frp_deframer.sv
// ----------------------------------------------------------------------------
// frp_deframer
// Frame state machine: sync hunt, header capture, payload and check byte.
// ----------------------------------------------------------------------------
module frp_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [15:0]       max_len_i,
  output frp_pkg::result_t  res_o
);

  frp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [15:0] len_hi_val;
  logic [7:0]  sum_add;
  logic [7:0]  expect_byte;
  logic        over_limit;

  assign len_hi_val  = {rx_byte_i, len_q[7:0]};
  assign over_limit  = len_hi_val > max_len_i;
  assign sum_add     = sum_q + rx_byte_i;
  assign expect_byte = 8'd0 - sum_q;

  // next state
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    id_d    = id_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    left_d  = left_q;
    if (step_i) begin
      case (phase_q)
        frp_pkg::PH_HUNT2: begin
          if (rx_byte_i == frp_pkg::SYNC_B) begin
            phase_d = frp_pkg::PH_HUNT3;
          end else if (rx_byte_i == frp_pkg::SYNC_A) begin
            phase_d = frp_pkg::PH_HUNT2;
          end else begin
            phase_d = frp_pkg::PH_HUNT1;
          end
        end
        frp_pkg::PH_HUNT3: begin
          if (rx_byte_i == frp_pkg::SYNC_C) begin
            phase_d = frp_pkg::PH_ID;
          end else if (rx_byte_i == frp_pkg::SYNC_A) begin
            phase_d = frp_pkg::PH_HUNT2;
          end else begin
            phase_d = frp_pkg::PH_HUNT1;
          end
        end
        frp_pkg::PH_ID: begin
          id_d    = rx_byte_i;
          sum_d   = rx_byte_i;
          phase_d = frp_pkg::PH_CMD_LO;
        end
        frp_pkg::PH_CMD_LO: begin
          cmd_d   = {8'd0, rx_byte_i};
          sum_d   = sum_add;
          phase_d = frp_pkg::PH_CMD_HI;
        end
        frp_pkg::PH_CMD_HI: begin
          cmd_d   = {rx_byte_i, cmd_q[7:0]};
          sum_d   = sum_add;
          phase_d = frp_pkg::PH_LEN_LO;
        end
        frp_pkg::PH_LEN_LO: begin
          len_d   = {8'd0, rx_byte_i};
          sum_d   = sum_add;
          phase_d = frp_pkg::PH_LEN_HI;
        end
        frp_pkg::PH_LEN_HI: begin
          len_d = len_hi_val;
          sum_d = sum_add;
          if (over_limit) begin
            phase_d = frp_pkg::PH_HUNT1;
          end else begin
            left_d  = len_hi_val;
            phase_d = (len_hi_val == 16'd0) ? frp_pkg::PH_CHECK : frp_pkg::PH_PAYLOAD;
          end
        end
        frp_pkg::PH_PAYLOAD: begin
          sum_d  = sum_add;
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            phase_d = frp_pkg::PH_CHECK;
          end
        end
        frp_pkg::PH_CHECK: begin
          phase_d = frp_pkg::PH_HUNT1;
        end
        default: begin
          phase_d = (rx_byte_i == frp_pkg::SYNC_A) ? frp_pkg::PH_HUNT2 : frp_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res_o.valid        = 1'b0;
    res_o.item_kind    = frp_pkg::KIND_REPORT;
    res_o.payload_byte = 8'd0;
    res_o.frame_id     = id_d;
    res_o.command_word = cmd_d;
    res_o.payload_len  = len_d;
    res_o.frame_status = frp_pkg::ST_OK;
    case (phase_q)
      frp_pkg::PH_LEN_HI: begin
        res_o.valid        = step_i && over_limit;
        res_o.frame_status = frp_pkg::ST_LEN_ERR;
      end
      frp_pkg::PH_PAYLOAD: begin
        res_o.valid        = step_i;
        res_o.item_kind    = frp_pkg::KIND_PAYLOAD;
        res_o.payload_byte = rx_byte_i;
      end
      frp_pkg::PH_CHECK: begin
        res_o.valid        = step_i;
        res_o.frame_status = (rx_byte_i == expect_byte) ? frp_pkg::ST_OK
                                                        : frp_pkg::ST_CSUM_ERR;
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= frp_pkg::PH_HUNT1;
      sum_q   <= 8'd0;
      id_q    <= 8'd0;
      cmd_q   <= 16'd0;
      len_q   <= 16'd0;
      left_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      id_q    <= id_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> rtl/frp_out_reg.sv
// ----------------------------------------------------------------------------
// frp_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module frp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frp_pkg::result_t  res_i,
  output logic              ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata,  // [7:0] payload_byte, [15:8] frame_id,
                                           // [31:16] command_word, [47:32] payload_len,
                                           // [49:48] frame_status, rest zero
  output logic [0:0]        m_axis_tuser   // [0] item_kind
);

  logic             valid_q, valid_d;
  frp_pkg::result_t res_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid && ready_o) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid && ready_o) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.item_kind;
  assign m_axis_tdata  = {6'd0, res_q.frame_status, res_q.payload_len,
                          res_q.command_word, res_q.frame_id, res_q.payload_byte};

endmodule

>>> rtl/framed_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_core
// Byte-serial deframer: sync hunt, header, payload pass-through, check byte.
// ----------------------------------------------------------------------------
// Path: input register, combinational frame state machine, result register.
// Throughput: one byte per cycle while the result register can take a result.
// Reset: asynchronous, active low; hunting the first sync byte, sums and
// header fields zero, payload limit 119, both stream sides empty.
// ----------------------------------------------------------------------------
module framed_packet_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // max_payload_len
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_id,
                                      // [31:16] command_word, [47:32] payload_len,
                                      // [49:48] frame_status, rest zero
  output logic [0:0]  m_axis_tuser    // [0] item_kind
);

  logic [15:0]        max_len_q;
  logic               out_ready;
  logic               step;
  frp_pkg::in_stage_t stage;
  frp_pkg::result_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= frp_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign step = stage.valid && out_ready;

  frp_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take_i        (step),
    .stage_o       (stage)
  );

  frp_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (stage.rx_byte),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  frp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> test/framed_packet_receiver_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_scoreboard
// Watches the byte stream and the result stream of the deframer. It runs its
// own deframing state machine on every accepted byte and queues the payload
// bytes and frame reports that it predicts. Each result transfer is compared
// field by field with the oldest queued item.
// ----------------------------------------------------------------------------
module framed_packet_receiver_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  input  logic [0:0]  m_tuser_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [7:0]  fid;
    logic [15:0] cmd;
    logic [15:0] plen;
    logic [1:0]  status;
  } frame_item_t;

  frame_item_t frame_items_q[$];

  frp_pkg::phase_e rx_phase;
  logic [15:0]     len_limit;
  logic [7:0]      hdr_sum;
  logic [7:0]      hdr_id;
  logic [15:0]     hdr_cmd;
  logic [15:0]     hdr_len;
  logic [15:0]     left_cnt;

  task automatic queue_item(input logic kind, input logic [7:0] pbyte,
                            input logic [1:0] status);
    frame_item_t it;
    it.kind   = kind;
    it.pbyte  = pbyte;
    it.fid    = hdr_id;
    it.cmd    = hdr_cmd;
    it.plen   = hdr_len;
    it.status = status;
    frame_items_q.push_back(it);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] want_check;
    want_check = 8'h00 - hdr_sum;
    case (rx_phase)
      frp_pkg::PH_HUNT2: begin
        if (b == frp_pkg::SYNC_B) rx_phase = frp_pkg::PH_HUNT3;
        else rx_phase = (b == frp_pkg::SYNC_A) ? frp_pkg::PH_HUNT2 : frp_pkg::PH_HUNT1;
      end
      frp_pkg::PH_HUNT3: begin
        if (b == frp_pkg::SYNC_C) rx_phase = frp_pkg::PH_ID;
        else rx_phase = (b == frp_pkg::SYNC_A) ? frp_pkg::PH_HUNT2 : frp_pkg::PH_HUNT1;
      end
      frp_pkg::PH_ID: begin
        hdr_id   = b;
        hdr_sum  = b;
        rx_phase = frp_pkg::PH_CMD_LO;
      end
      frp_pkg::PH_CMD_LO: begin
        hdr_cmd  = {8'h00, b};
        hdr_sum  = hdr_sum + b;
        rx_phase = frp_pkg::PH_CMD_HI;
      end
      frp_pkg::PH_CMD_HI: begin
        hdr_cmd[15:8] = b;
        hdr_sum       = hdr_sum + b;
        rx_phase      = frp_pkg::PH_LEN_LO;
      end
      frp_pkg::PH_LEN_LO: begin
        hdr_len  = {8'h00, b};
        hdr_sum  = hdr_sum + b;
        rx_phase = frp_pkg::PH_LEN_HI;
      end
      frp_pkg::PH_LEN_HI: begin
        hdr_len[15:8] = b;
        hdr_sum       = hdr_sum + b;
        if (hdr_len > len_limit) begin
          rx_phase = frp_pkg::PH_HUNT1;
          queue_item(frp_pkg::KIND_REPORT, 8'h00, frp_pkg::ST_LEN_ERR);
        end else begin
          left_cnt = hdr_len;
          rx_phase = (hdr_len == 16'd0) ? frp_pkg::PH_CHECK : frp_pkg::PH_PAYLOAD;
        end
      end
      frp_pkg::PH_PAYLOAD: begin
        hdr_sum  = hdr_sum + b;
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == 16'd0) rx_phase = frp_pkg::PH_CHECK;
        queue_item(frp_pkg::KIND_PAYLOAD, b, frp_pkg::ST_OK);
      end
      frp_pkg::PH_CHECK: begin
        rx_phase = frp_pkg::PH_HUNT1;
        queue_item(frp_pkg::KIND_REPORT, 8'h00,
                   (b == want_check) ? frp_pkg::ST_OK : frp_pkg::ST_CSUM_ERR);
      end
      default: begin
        rx_phase = (b == frp_pkg::SYNC_A) ? frp_pkg::PH_HUNT2 : frp_pkg::PH_HUNT1;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors_o++;
    end
  endtask

  task automatic compare_result();
    frame_item_t want;
    if (frame_items_q.size() == 0) begin
      $error("result transfer with nothing pending: tdata %0h, tuser %0h",
             m_tdata_i, m_tuser_i);
      errors_o++;
    end else begin
      want = frame_items_q.pop_front();
      compare_field("item_kind",    {15'd0, want.kind},  {15'd0, m_tuser_i[0]});
      compare_field("payload_byte", {8'd0, want.pbyte},  {8'd0, m_tdata_i[7:0]});
      compare_field("frame_id",     {8'd0, want.fid},    {8'd0, m_tdata_i[15:8]});
      compare_field("command_word", want.cmd,            m_tdata_i[31:16]);
      compare_field("payload_len",  want.plen,           m_tdata_i[47:32]);
      compare_field("frame_status", {14'd0, want.status}, {14'd0, m_tdata_i[49:48]});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase  = frp_pkg::PH_HUNT1;
      len_limit = frp_pkg::MAX_LEN_RESET;
      hdr_sum   = 8'h00;
      hdr_id    = 8'h00;
      hdr_cmd   = 16'h0000;
      hdr_len   = 16'h0000;
      left_cnt  = 16'h0000;
      frame_items_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) len_limit = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) deframe_byte(s_tdata_i);
      if (m_tvalid_i && m_tready_i) compare_result();
      pending_o = frame_items_q.size();
    end
  end

endmodule

>>> test/framed_packet_receiver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_core_tb
// Drives byte streams into the deframer: a short directed run over sync
// mismatches, a zero-length frame and an oversized header, then random frames,
// corrupted check bytes, cut frames and noise under several payload limits,
// with random stalls on both stream sides. The verdict follows from the
// scoreboard's failure count and its pending items.
// ----------------------------------------------------------------------------
module framed_packet_receiver_core_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int          errors;
  int          pending;
  int          cycles;
  int          bytes_sent;
  logic        calm;
  logic [15:0] cur_limit;

  framed_packet_receiver_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  framed_packet_receiver_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(99) < 32) begin
      gap = $urandom_range(1, 2);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    cur_limit    = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // cut_at < 0 or >= len sends whole frame; else stop after that many payload bytes
  task automatic send_frame(input logic [7:0] id, input logic [15:0] cmd,
                            input logic [15:0] len, input logic corrupt,
                            input int cut_at);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    sum = id + cmd[7:0] + cmd[15:8] + len[7:0] + len[15:8];
    send_byte(frp_pkg::SYNC_A);
    send_byte(frp_pkg::SYNC_B);
    send_byte(frp_pkg::SYNC_C);
    send_byte(id);
    send_byte(cmd[7:0]);
    send_byte(cmd[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len > cur_limit) return;
    for (int i = 0; i < len; i++) begin
      if (i == cut_at) return;
      b   = $urandom_range(255);
      sum = sum + b;
      send_byte(b);
    end
    chk = 8'h00 - sum;
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 12));
    if (r < 90 || cur_limit == 16'hFFFF) return 16'($urandom_range(13, 48));
    if (r < 95) return cur_limit + 16'($urandom_range(1, 3));
    return 16'($urandom_range(int'(cur_limit) + 1, 65535));
  endfunction

  task automatic send_random_run();
    int r;
    int n;
    logic [15:0] len;
    r = $urandom_range(99);
    if (r < 80) begin
      send_frame(8'($urandom_range(255)), 16'($urandom_range(65535)), pick_len(),
                 $urandom_range(99) < 25, -1);
    end else if (r < 90) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (r < 95) begin
      send_byte(frp_pkg::SYNC_A);
      if ($urandom_range(1)) send_byte(frp_pkg::SYNC_B);
      send_byte(8'($urandom_range(255)));
    end else begin
      len = 16'($urandom_range(2, 12));
      if (len > cur_limit) len = cur_limit;
      send_frame(8'($urandom_range(255)), 16'($urandom_range(65535)), len, 1'b0,
                 $urandom_range(0, int'(len)));
    end
  endtask

  initial begin
    logic [15:0] lim;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 16'h0000;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    cycles        = 0;
    bytes_sent    = 0;
    calm          = 1'b0;
    cur_limit     = frp_pkg::MAX_LEN_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sync mismatches: non-sync and a fresh 0x21 at each hunting step
    send_byte(frp_pkg::SYNC_A); send_byte(8'h00);
    send_byte(frp_pkg::SYNC_A); send_byte(frp_pkg::SYNC_B); send_byte(8'h00);
    send_byte(frp_pkg::SYNC_A); send_byte(frp_pkg::SYNC_A);
    send_byte(frp_pkg::SYNC_B); send_byte(frp_pkg::SYNC_A);
    // zero-length frame with all-ones header fields, good check byte
    send_frame(8'hFF, 16'hFFFF, 16'h0000, 1'b0, -1);
    // oversized header under the reset limit
    send_frame(8'h00, 16'h0000, 16'hFFFF, 1'b0, -1);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       lim = 16'd0;
        1:       lim = 16'hFFFF;
        2:       lim = 16'd1;
        3:       lim = frp_pkg::MAX_LEN_RESET;
        default: lim = 16'($urandom_range(2, 40));
      endcase
      write_limit(lim);
      calm = (p == 3);
      while (bytes_sent < 25 + (p + 1) * 290) send_random_run();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
